[src/eq_pkg.sv]
`default_nettype none
package eq_pkg;

	localparam int CORDIC_ITERS = 24;
	localparam int STEP_BITS = 5;
	localparam int TRIG_BITS = 32;
	localparam int PHASE_BITS = 34;
	localparam int FIELD_BITS = 16;

	localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam int AX_ROLL = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW = 2;

	localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic signed [TRIG_BITS-1:0]  x;
		logic signed [TRIG_BITS-1:0]  y;
		logic signed [PHASE_BITS-1:0] ph;
	} eq_rot_t;

	typedef eq_rot_t [2:0] eq_rot3_t;

	typedef struct packed {
		logic signed [TRIG_BITS-1:0] c;
		logic signed [TRIG_BITS-1:0] s;
	} eq_sc_t;

	typedef eq_sc_t [2:0] eq_sc3_t;

endpackage
`default_nettype wire

[src/euler_to_quaternion_top.sv]
`default_nettype none
// channel | valid     | stall     | fields
// input   | in_valid  | in_stall  | roll_angle, pitch_angle, yaw_angle
// output  | out_valid | out_stall | quat_w, quat_x, quat_y, quat_z
//
// One beat per cycle in and one beat per cycle out while out_stall is low; the pipeline has
// 24 CORDIC rotation stages, then 4 product and rounding stages.
// Reset clears only the valid bits; the pipeline starts empty.
// A stall on out_stall backs up stage by stage; empty stages keep filling.
module euler_to_quaternion_top #(
	parameter int ANGLE_BITS = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ANGLE_BITS-1:0]         roll_angle,
	input  wire logic [ANGLE_BITS-1:0]         pitch_angle,
	input  wire logic [ANGLE_BITS-1:0]         yaw_angle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [eq_pkg::FIELD_BITS-1:0]      quat_w,
	output logic [eq_pkg::FIELD_BITS-1:0]      quat_x,
	output logic [eq_pkg::FIELD_BITS-1:0]      quat_y,
	output logic [eq_pkg::FIELD_BITS-1:0]      quat_z
);
	import eq_pkg::*;

	localparam int PH_SHIFT = 31 - ANGLE_BITS;

	logic     vld_c [CORDIC_ITERS+1];
	logic     stl_c [CORDIC_ITERS+1];
	eq_rot3_t dat_c [CORDIC_ITERS+1];
	eq_sc3_t  sc;

	function automatic logic signed [PHASE_BITS-1:0] phase_of(input logic [ANGLE_BITS-1:0] a);
		logic signed [PHASE_BITS-1:0] p;
		p = $signed({{(PHASE_BITS-ANGLE_BITS){a[ANGLE_BITS-1]}}, a});
		return p <<< PH_SHIFT;
	endfunction

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dat_c[0][a].x = CORDIC_GAIN;
			dat_c[0][a].y = '0;
		end
		dat_c[0][AX_ROLL].ph  = phase_of(roll_angle);
		dat_c[0][AX_PITCH].ph = phase_of(pitch_angle);
		dat_c[0][AX_YAW].ph   = phase_of(yaw_angle);
	end

	assign vld_c[0] = in_valid;
	assign in_stall = stl_c[0];

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
		eq_cordic_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_idx (STEP_BITS'(i)),
			.up_valid (vld_c[i]),
			.up_stall (stl_c[i]),
			.up_data  (dat_c[i]),
			.dn_valid (vld_c[i+1]),
			.dn_data  (dat_c[i+1]),
			.dn_stall (stl_c[i+1])
		);
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sc[a].c = dat_c[CORDIC_ITERS][a].x;
			sc[a].s = dat_c[CORDIC_ITERS][a].y;
		end
	end

	eq_quat #(
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_quat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_c[CORDIC_ITERS]),
		.up_stall (stl_c[CORDIC_ITERS]),
		.up_data  (sc),
		.dn_valid (out_valid),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.dn_stall (out_stall)
	);

endmodule
`default_nettype wire

[src/eq_cordic_stage.sv]
`default_nettype none
module eq_cordic_stage (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [eq_pkg::STEP_BITS-1:0]  step_idx,
	input  wire logic                          up_valid,
	output logic                               up_stall,
	input  wire eq_pkg::eq_rot3_t              up_data,
	output logic                               dn_valid,
	output eq_pkg::eq_rot3_t                   dn_data,
	input  wire logic                          dn_stall
);
	import eq_pkg::*;

	logic     vld_s1;
	eq_rot3_t data_s1;
	eq_rot3_t nxt;
	logic signed [PHASE_BITS-1:0] atan_ext;

	assign atan_ext = $signed({2'b00, ATAN_TURN[step_idx]});

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (!up_data[a].ph[PHASE_BITS-1]) begin
				nxt[a].x  = $signed(up_data[a].x) - ($signed(up_data[a].y) >>> step_idx);
				nxt[a].y  = $signed(up_data[a].y) + ($signed(up_data[a].x) >>> step_idx);
				nxt[a].ph = $signed(up_data[a].ph) - atan_ext;
			end else begin
				nxt[a].x  = $signed(up_data[a].x) + ($signed(up_data[a].y) >>> step_idx);
				nxt[a].y  = $signed(up_data[a].y) - ($signed(up_data[a].x) >>> step_idx);
				nxt[a].ph = $signed(up_data[a].ph) + atan_ext;
			end
		end
	end

	assign up_stall = vld_s1 && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!up_stall) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_data  = data_s1;

endmodule
`default_nettype wire

[src/eq_quat.sv]
`default_nettype none
module eq_quat #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            up_valid,
	output logic                                 up_stall,
	input  wire eq_pkg::eq_sc3_t                 up_data,
	output logic                                 dn_valid,
	output logic [eq_pkg::FIELD_BITS-1:0]        quat_w,
	output logic [eq_pkg::FIELD_BITS-1:0]        quat_x,
	output logic [eq_pkg::FIELD_BITS-1:0]        quat_y,
	output logic [eq_pkg::FIELD_BITS-1:0]        quat_z,
	input  wire logic                            dn_stall
);
	import eq_pkg::*;

	localparam int PROD_BITS = 2 * TRIG_BITS;
	localparam int SUM_BITS = PROD_BITS + 1;
	localparam int RND_SHIFT = 60 - QUAT_FRAC_BITS;

	localparam logic signed [SUM_BITS-1:0] RND_HALF = SUM_BITS'(1) <<< (RND_SHIFT - 1);
	localparam logic signed [SUM_BITS-1:0] LIM_POS  = SUM_BITS'(1) <<< QUAT_FRAC_BITS;
	localparam logic signed [SUM_BITS-1:0] LIM_NEG  = -LIM_POS;

	logic [4:1] vld;
	logic [4:1] stl;

	logic signed [TRIG_BITS-1:0] p_cc_s1, p_ss_s1, p_sc_s1, p_cs_s1;
	logic signed [TRIG_BITS-1:0] cy_s1, sy_s1;
	logic signed [PROD_BITS-1:0] t_s2 [8];
	logic signed [SUM_BITS-1:0]  sum_s3 [4];
	logic [FIELD_BITS-1:0]       q_s4 [4];
	logic signed [SUM_BITS-1:0]  sat [4];

	function automatic logic signed [TRIG_BITS-1:0] rnd30(
		input logic signed [TRIG_BITS-1:0] a,
		input logic signed [TRIG_BITS-1:0] b
	);
		logic signed [PROD_BITS-1:0] p;
		p = PROD_BITS'(a) * PROD_BITS'(b);
		p = p + (PROD_BITS'(1) <<< 29);
		return p[TRIG_BITS+29:30];
	endfunction

	function automatic logic signed [SUM_BITS-1:0] quant(input logic signed [SUM_BITS-1:0] v);
		logic signed [SUM_BITS-1:0] r;
		r = (v + RND_HALF) >>> RND_SHIFT;
		if (r > LIM_POS) begin
			r = LIM_POS;
		end
		if (r < LIM_NEG) begin
			r = LIM_NEG;
		end
		return r;
	endfunction

	assign stl[4] = vld[4] && dn_stall;
	assign stl[3] = vld[3] && stl[4];
	assign stl[2] = vld[2] && stl[3];
	assign stl[1] = vld[1] && stl[2];
	assign up_stall = stl[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (!stl[1]) vld[1] <= up_valid;
			if (!stl[2]) vld[2] <= vld[1];
			if (!stl[3]) vld[3] <= vld[2];
			if (!stl[4]) vld[4] <= vld[3];
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sat[k] = quant(sum_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (!stl[1] && up_valid) begin
			p_cc_s1 <= rnd30(up_data[AX_ROLL].c, up_data[AX_PITCH].c);
			p_ss_s1 <= rnd30(up_data[AX_ROLL].s, up_data[AX_PITCH].s);
			p_sc_s1 <= rnd30(up_data[AX_ROLL].s, up_data[AX_PITCH].c);
			p_cs_s1 <= rnd30(up_data[AX_ROLL].c, up_data[AX_PITCH].s);
			cy_s1   <= up_data[AX_YAW].c;
			sy_s1   <= up_data[AX_YAW].s;
		end
		if (!stl[2] && vld[1]) begin
			t_s2[0] <= PROD_BITS'(p_cc_s1) * PROD_BITS'(cy_s1);
			t_s2[1] <= PROD_BITS'(p_ss_s1) * PROD_BITS'(sy_s1);
			t_s2[2] <= PROD_BITS'(p_sc_s1) * PROD_BITS'(cy_s1);
			t_s2[3] <= PROD_BITS'(p_cs_s1) * PROD_BITS'(sy_s1);
			t_s2[4] <= PROD_BITS'(p_cs_s1) * PROD_BITS'(cy_s1);
			t_s2[5] <= PROD_BITS'(p_sc_s1) * PROD_BITS'(sy_s1);
			t_s2[6] <= PROD_BITS'(p_cc_s1) * PROD_BITS'(sy_s1);
			t_s2[7] <= PROD_BITS'(p_ss_s1) * PROD_BITS'(cy_s1);
		end
		if (!stl[3] && vld[2]) begin
			sum_s3[0] <= SUM_BITS'(t_s2[0]) + SUM_BITS'(t_s2[1]);
			sum_s3[1] <= SUM_BITS'(t_s2[2]) - SUM_BITS'(t_s2[3]);
			sum_s3[2] <= SUM_BITS'(t_s2[4]) + SUM_BITS'(t_s2[5]);
			sum_s3[3] <= SUM_BITS'(t_s2[6]) - SUM_BITS'(t_s2[7]);
		end
		if (!stl[4] && vld[3]) begin
			for (int k = 0; k < 4; k++) begin
				q_s4[k] <= sat[k][FIELD_BITS-1:0];
			end
		end
	end

	assign dn_valid = vld[4];
	assign quat_w = q_s4[0];
	assign quat_x = q_s4[1];
	assign quat_y = q_s4[2];
	assign quat_z = q_s4[3];

`ifndef SYNTHESIS
	a_sat_w: assert property (@(posedge clk) disable iff (!arst_n)
		vld[3] |-> (sat[0] <= LIM_POS && sat[0] >= LIM_NEG))
		else $error("w component past clamp");
	a_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld[3] |-> (sat[1] <= LIM_POS && sat[1] >= LIM_NEG))
		else $error("x component past clamp");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[3] && !stl[4]) |=> vld[4])
		else $error("beat dropped at final stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[2] && stl[2]) |=> vld[2])
		else $error("stalled beat lost in product stage");
`endif

endmodule
`default_nettype wire

[tb/euler_to_quaternion_checker.sv]
`timescale 1ns / 100ps
module euler_to_quaternion_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [15:0] roll_angle,
	input  wire logic [15:0] pitch_angle,
	input  wire logic [15:0] yaw_angle,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] quat_w,
	input  wire logic [15:0] quat_x,
	input  wire logic [15:0] quat_y,
	input  wire logic [15:0] quat_z,
	output int               fail_count,
	output int               pending
);
	import eq_pkg::*;

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} quat_t;

	quat_t quat_q[$];

	task automatic half_sin_cos(input logic [15:0] ang, output longint c, output longint s);
		longint ph, xv, yv, dx, dy;
		ph = longint'($signed(ang)) * 64'sd32768;
		xv = CORDIC_GAIN;
		yv = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (ph >= 0) begin
				xv -= dx;
				yv += dy;
				ph -= longint'(ATAN_TURN[i]);
			end else begin
				xv += dx;
				yv -= dy;
				ph += longint'(ATAN_TURN[i]);
			end
		end
		c = xv;
		s = yv;
	endtask

	function automatic longint triple_prod(longint a, longint b, longint c);
		longint ab;
		ab = (a * b + 64'sd536870912) >>> 30;
		return ab * c;
	endfunction

	function automatic logic [15:0] to_q14(longint v);
		longint r;
		r = (v + (64'sd1 <<< 45)) >>> 46;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r[15:0];
	endfunction

	task automatic predict_quat(input logic [15:0] r, p, yw, output quat_t q);
		longint cr, sr, cp, sp, cy, sy;
		half_sin_cos(r, cr, sr);
		half_sin_cos(p, cp, sp);
		half_sin_cos(yw, cy, sy);
		q.w = to_q14(triple_prod(cr, cp, cy) + triple_prod(sr, sp, sy));
		q.x = to_q14(triple_prod(sr, cp, cy) - triple_prod(cr, sp, sy));
		q.y = to_q14(triple_prod(cr, sp, cy) + triple_prod(sr, cp, sy));
		q.z = to_q14(triple_prod(cr, cp, sy) - triple_prod(sr, sp, cy));
	endtask

	task automatic check_field(string nm, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t %s expected %0d actual %0d", $time, nm, $signed(exp_v),
				$signed(act_v));
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		quat_t q, e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_quat(roll_angle, pitch_angle, yaw_angle, q);
				quat_q = {quat_q, q};
			end
			if (out_valid && !out_stall) begin
				if (quat_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected beat expected none actual %h %h %h %h", $time,
						quat_w, quat_x, quat_y, quat_z);
				end else begin
					e = quat_q.pop_front();
					check_field("quat_w", e.w, quat_w);
					check_field("quat_x", e.x, quat_x);
					check_field("quat_y", e.y, quat_y);
					check_field("quat_z", e.z, quat_z);
				end
			end
		end
		pending = quat_q.size();
	end
endmodule

[tb/euler_to_quaternion_top_tb.sv]
`timescale 1ns / 100ps
module euler_to_quaternion_top_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic [15:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
	logic in_stall, out_valid;
	logic [15:0] quat_w, quat_x, quat_y, quat_z;
	int fail_count, pending;
	int cycle_count = 0;
	logic hold_done = 0;
	logic [15:0] angle_list[$];

	always #10 clk = ~clk;

	euler_to_quaternion_top uut (
		.clk, .arst_n, .in_valid, .in_stall, .roll_angle, .pitch_angle, .yaw_angle,
		.out_valid, .out_stall, .quat_w, .quat_x, .quat_y, .quat_z
	);

	euler_to_quaternion_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .roll_angle, .pitch_angle, .yaw_angle,
		.out_valid, .out_stall, .quat_w, .quat_x, .quat_y, .quat_z,
		.fail_count, .pending
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: one long hold early, then random stall pattern
	initial begin
		int mode;
		@(posedge arst_n);
		repeat (40) @(posedge clk);
		out_stall <= 1;
		repeat (150) @(posedge clk);
		hold_done = 1;
		forever begin
			@(posedge clk);
			mode = (cycle_count / 300) % 3;
			if (mode == 0) out_stall <= 0;
			else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
			else out_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	task automatic send_beat(input logic [15:0] r, p, yw);
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= yw;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return angle_list[$urandom_range(0, angle_list.size() - 1)];
			1: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int sent, burst, gap;
		angle_list = '{16'h0000, 16'h7fff, 16'h8000, 16'h8001, 16'h4000, 16'hc000,
			16'h2000, 16'he000, 16'h0001, 16'hffff, 16'h5555, 16'haaaa};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (angle_list[i]) send_beat(angle_list[i], 16'h0000, 16'h0000);
		send_beat(16'h0000, 16'h8000, 16'h0000);
		send_beat(16'h0000, 16'h0000, 16'h8000);
		send_beat(16'h8000, 16'h8000, 16'h8000);
		send_beat(16'h7fff, 16'h7fff, 16'h7fff);
		send_beat(16'h4000, 16'h4000, 16'h4000);
		send_beat(16'h2000, 16'hc000, 16'h6000);
		// keep offering during the long hold so the pipeline backs up
		while (!hold_done) send_beat(rand_angle(), rand_angle(), rand_angle());
		sent = 0;
		while (sent < 1030) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst; b++) begin
				send_beat(rand_angle(), rand_angle(), rand_angle());
				sent++;
			end
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
